/* design/bbas_pkg.sv */
// ----------------------------------------------------------------------------
// bbas_pkg: shared types and constants for the BCD/binary add-subtract unit
// Word layouts for both channels, variant codes and decimal correction values.
// ----------------------------------------------------------------------------
package bbas_pkg;

  localparam int DataW = 8;
  localparam int NibW  = 4;

  // Decimal correction constants
  localparam logic [NibW:0]    DecLimit  = 5'd9;
  localparam logic [NibW:0]    DecAdjust = 5'd10;
  localparam logic [DataW-1:0] DecAdjW   = 8'd10;

  // CPU variant codes
  localparam logic VariantNmos = 1'b0;
  localparam logic VariantCmos = 1'b1;

  // Operation codes
  localparam logic OpAdc = 1'b0;
  localparam logic OpSbc = 1'b1;

  typedef struct packed {
    logic             operation;
    logic             decimal_mode;
    logic             carry_in;
    logic [DataW-1:0] accumulator_in;
    logic [DataW-1:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] accumulator_out;
    logic             negative_flag;
    logic             overflow_flag;
    logic             zero_flag;
    logic             carry_out;
  } out_word_t;

endpackage

/* design/bbas_alu.sv */
// ----------------------------------------------------------------------------
// bbas_alu: add/subtract core with binary and decimal modes
// Combinational; produces accumulator and N, V, Z, C for both CPU variants.
// ----------------------------------------------------------------------------
module bbas_alu (
  input  bbas_pkg::in_word_t  op_i,
  input  logic                variant_i,
  output bbas_pkg::out_word_t res_o
);
  import bbas_pkg::*;

  logic [DataW-1:0] a, b;
  logic             a7, b7, cin, brw;

  // binary add
  logic [DataW:0]   add_full;
  logic             add_n, add_v;

  // decimal add
  logic [NibW:0]    dadd_lo, dadd_hi, dadd_lo_adj, dadd_hi_adj;
  logic             dadd_clo, dadd_c, dadd_pn, dadd_v;
  logic [DataW-1:0] dadd_acc;

  // binary subtract
  logic [DataW:0]   sub_full;
  logic             sub_n, sub_v;

  // decimal subtract
  logic [DataW-1:0] dsub_lo, dsub_lo_adj, dsub_hi, dsub_hi_adj;
  logic             dsub_bl, dsub_still_neg, dsub_pn, dsub_bh, dsub_cv;
  logic [NibW-1:0]  dsub_hi_cmos;
  logic [DataW-1:0] dsub_acc_nmos, dsub_acc_cmos;

  assign a   = op_i.accumulator_in;
  assign b   = op_i.operand_value;
  assign a7  = a[DataW-1];
  assign b7  = b[DataW-1];
  assign cin = op_i.carry_in;
  assign brw = ~cin;

  assign add_full = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, cin};
  assign add_n    = add_full[DataW-1];
  assign add_v    = (a7 ^ add_n) & (b7 ^ add_n);

  // Decimal add: correct low digit, ripple its carry, correct high digit
  assign dadd_lo     = {1'b0, a[NibW-1:0]} + {1'b0, b[NibW-1:0]} + {{NibW{1'b0}}, cin};
  assign dadd_clo    = dadd_lo > DecLimit;
  assign dadd_lo_adj = dadd_clo ? (dadd_lo - DecAdjust) : dadd_lo;
  assign dadd_hi     = {1'b0, a[DataW-1:NibW]} + {1'b0, b[DataW-1:NibW]}
                     + {{NibW{1'b0}}, dadd_clo};
  assign dadd_pn     = dadd_hi[NibW-1];
  assign dadd_v      = (a7 ^ dadd_pn) & (b7 ^ dadd_pn);
  assign dadd_c      = dadd_hi > DecLimit;
  assign dadd_hi_adj = dadd_c ? (dadd_hi - DecAdjust) : dadd_hi;
  assign dadd_acc    = {dadd_hi_adj[NibW-1:0], dadd_lo_adj[NibW-1:0]};

  assign sub_full = {1'b0, a} - {1'b0, b} - {{DataW{1'b0}}, brw};
  assign sub_n    = sub_full[DataW-1];
  assign sub_v    = (a7 ^ sub_n) & (~b7 ^ sub_n);

  // Decimal subtract: digits worked in byte width so a negative digit shows in bit 7
  assign dsub_lo        = {{NibW{1'b0}}, a[NibW-1:0]} - {{NibW{1'b0}}, b[NibW-1:0]}
                        - {{(DataW-1){1'b0}}, brw};
  assign dsub_bl        = dsub_lo[DataW-1];
  assign dsub_lo_adj    = dsub_bl ? (dsub_lo + DecAdjW) : dsub_lo;
  assign dsub_still_neg = dsub_lo_adj[DataW-1];
  assign dsub_hi        = {{NibW{1'b0}}, a[DataW-1:NibW]} - {{NibW{1'b0}}, b[DataW-1:NibW]}
                        - {{(DataW-1){1'b0}}, dsub_bl};
  assign dsub_pn        = dsub_hi[NibW-1];
  assign dsub_bh        = dsub_hi[DataW-1];
  assign dsub_hi_adj    = dsub_bh ? (dsub_hi + DecAdjW) : dsub_hi;
  assign dsub_hi_cmos   = dsub_hi_adj[NibW-1:0] - {{(NibW-1){1'b0}}, dsub_still_neg};
  assign dsub_cv        = (a7 ^ dsub_pn) & (~b7 ^ dsub_pn);
  assign dsub_acc_nmos  = {dsub_hi_adj[NibW-1:0], dsub_lo_adj[NibW-1:0]};
  assign dsub_acc_cmos  = {dsub_hi_cmos, dsub_lo_adj[NibW-1:0]};

  always_comb begin
    res_o = '0;
    case ({op_i.operation, op_i.decimal_mode})
      {OpAdc, 1'b0}: begin
        res_o.accumulator_out = add_full[DataW-1:0];
        res_o.negative_flag   = add_n;
        res_o.overflow_flag   = add_v;
        res_o.zero_flag       = add_full[DataW-1:0] == '0;
        res_o.carry_out       = add_full[DataW];
      end
      {OpAdc, 1'b1}: begin
        res_o.accumulator_out = dadd_acc;
        res_o.overflow_flag   = dadd_v;
        res_o.carry_out       = dadd_c;
        if (variant_i == VariantCmos) begin
          res_o.negative_flag = dadd_acc[DataW-1];
          res_o.zero_flag     = dadd_acc == '0;
        end else begin
          res_o.negative_flag = dadd_pn;
          res_o.zero_flag     = add_full[DataW-1:0] == '0;
        end
      end
      {OpSbc, 1'b0}: begin
        res_o.accumulator_out = sub_full[DataW-1:0];
        res_o.negative_flag   = sub_n;
        res_o.overflow_flag   = sub_v;
        res_o.zero_flag       = sub_full[DataW-1:0] == '0;
        res_o.carry_out       = ~sub_full[DataW];
      end
      {OpSbc, 1'b1}: begin
        res_o.carry_out = ~dsub_bh;
        if (variant_i == VariantCmos) begin
          res_o.accumulator_out = dsub_acc_cmos;
          res_o.negative_flag   = dsub_acc_cmos[DataW-1];
          res_o.overflow_flag   = dsub_cv;
          res_o.zero_flag       = dsub_acc_cmos == '0;
        end else begin
          res_o.accumulator_out = dsub_acc_nmos;
          res_o.negative_flag   = sub_n;
          res_o.overflow_flag   = sub_v;
          res_o.zero_flag       = sub_full[DataW-1:0] == '0;
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule

/* design/bcd_binary_add_subtract_flags.sv */
// ----------------------------------------------------------------------------
// bcd_binary_add_subtract_flags: 8-bit ADC/SBC unit with binary and BCD modes
// Registered input word, single-pass arithmetic, registered result word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one word per operation:
//   operation, decimal mode, carry in, accumulator and operand.
//   Result channel (out_valid/out_ready/out_data) returns the new accumulator
//   and the N, V, Z and C flags, one result word per input word, in order.
//   cfg_wr_en/cfg_wr_data write the CPU variant bit (0 NMOS, 1 CMOS); write it
//   only while no word is in flight. It resets to NMOS.
//   The input register loads on accept, the result register from it once
//   free, raising out_valid. Throughput: one word per cycle while out_ready
//   is high, set by the two-register pipeline; between them sits binary and
//   corrected BCD arithmetic (5-bit digit adds, byte-wide digit subtracts).
//   Reset (rst_n low, synchronous) drops both stage valids and clears the
//   variant register.
//   When the receiver stalls, the result word holds in the output register,
//   the input register keeps one more word, and in_ready falls only when both
//   are full and out_ready is low.
// ----------------------------------------------------------------------------
module bcd_binary_add_subtract_flags (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  bbas_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bbas_pkg::out_word_t out_data
);
  import bbas_pkg::*;

  logic      cpu_variant_r;
  logic      s1_vld_r, s1_vld_nxt;
  in_word_t  s1_word_r;
  logic      out_vld_r, out_vld_nxt;
  out_word_t out_word_r;
  out_word_t alu_res;
  logic      s1_adv;
  logic      in_acc;

  // Advance stage 1 into the result register whenever that register is free
  assign s1_adv   = ~out_vld_r | out_ready;
  assign in_ready = ~s1_vld_r | s1_adv;
  assign in_acc   = in_valid & in_ready;

  assign s1_vld_nxt  = in_acc | (s1_vld_r & ~s1_adv);
  assign out_vld_nxt = (s1_vld_r & s1_adv) | (out_vld_r & ~out_ready);

  bbas_alu u_alu (
    .op_i      (s1_word_r),
    .variant_i (cpu_variant_r),
    .res_o     (alu_res)
  );

  // Control state and variant register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_variant_r <= VariantNmos;
      s1_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cpu_variant_r <= cfg_wr_data;
      end
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: load only on a move, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_data;
    end
    if (s1_vld_r && s1_adv) begin
      out_word_r <= alu_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  // A full pipeline facing a stalled receiver takes no new word
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full");

  // A word in stage 1 that may advance shows up as a result next cycle
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_adv) |=> out_vld_r)
    else $error("stage 1 word lost on advance");

  // A blocked stage 1 word stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> (s1_vld_r && $stable(s1_word_r)))
    else $error("stage 1 word changed while blocked");

  // A stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> $stable(out_word_r))
    else $error("result register overwritten during stall");

endmodule

/* tb/bcd_binary_add_subtract_flags_tb.sv */
// ----------------------------------------------------------------------------
// bcd_binary_add_subtract_flags_tb: self-checking bench for the ADC/SBC unit
// Walks a short table of corner cases under both CPU variants, then runs
// phases of random words (mostly valid BCD in decimal mode) with random gaps
// on the input side and random stalls on the result side. Every result word
// is checked field by field against a hand-worked row or the bench predictor.
// ----------------------------------------------------------------------------
module bcd_binary_add_subtract_flags_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbas_pkg::*;

  localparam int PhaseCount   = 6;
  localparam int PhaseWords   = 250;
  localparam int SettleCycles = 4;   // two pipeline stages plus margin

  // One row of the directed table; known_res is used only when known_ok is set
  typedef struct {
    in_word_t  word;
    bit        known_ok;
    out_word_t known_res;
  } step_row_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  logic      cfg_wr_data;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // Bench-side copy of the variant register and the words still in flight
  logic      variant_now;
  out_word_t pending_results[$];
  step_row_t corner_steps[14];

  int error_count;
  int words_sent;
  int decimal_sent;
  int results_seen;
  int cfg_writes;

  bcd_binary_add_subtract_flags dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Compute the accumulator and N, V, Z, C for one word under a given variant
  function automatic out_word_t predict_adc_sbc(in_word_t w, logic variant);
    logic [8:0] full;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] bin;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] acc;
    logic       cin;
    logic       brw;
    logic       c;
    logic       pn;
    logic       v;
    logic       nb;
    logic       vb;
    logic       bl;
    logic       bh;
    logic       still_neg;
    out_word_t  r;
    a   = w.accumulator_in;
    b   = w.operand_value;
    cin = w.carry_in;
    if (w.operation == OpAdc) begin
      full = {1'b0, a} + {1'b0, b} + cin;
      bin  = full[7:0];
      if (!w.decimal_mode) begin
        r.accumulator_out = bin;
        r.negative_flag   = bin[7];
        r.overflow_flag   = (a[7] ^ bin[7]) & (b[7] ^ bin[7]);
        r.zero_flag       = (bin == 8'h00);
        r.carry_out       = full[8];
      end else begin
        // Low digit: correct past nine, keep four bits
        lo = {4'h0, a[3:0]} + {4'h0, b[3:0]} + cin;
        c  = (lo > 8'd9);
        if (c) lo = lo - DecAdjW;
        // High digit: V, and N on NMOS, come from the sum before correction
        hi = {4'h0, a[7:4]} + {4'h0, b[7:4]} + c;
        pn = hi[3];
        v  = (a[7] ^ pn) & (b[7] ^ pn);
        c  = (hi > 8'd9);
        if (c) hi = hi - DecAdjW;
        acc = {hi[3:0], lo[3:0]};
        r.accumulator_out = acc;
        r.overflow_flag   = v;
        r.carry_out       = c;
        if (variant == VariantNmos) begin
          r.negative_flag = pn;
          r.zero_flag     = (bin == 8'h00);
        end else begin
          r.negative_flag = acc[7];
          r.zero_flag     = (acc == 8'h00);
        end
      end
    end else begin
      brw = ~cin;
      bin = a - b - brw;
      nb  = bin[7];
      vb  = (a[7] ^ nb) & (~b[7] ^ nb);
      if (!w.decimal_mode) begin
        r.accumulator_out = bin;
        r.negative_flag   = nb;
        r.overflow_flag   = vb;
        r.zero_flag       = (bin == 8'h00);
        r.carry_out       = ({1'b0, a} >= ({1'b0, b} + brw));
      end else begin
        // Digits wrap as 8-bit values; a negative digit gets +10
        lo = {4'h0, a[3:0]} - {4'h0, b[3:0]} - brw;
        bl = lo[7];
        if (bl) lo = lo + DecAdjW;
        still_neg = lo[7];
        hi = {4'h0, a[7:4]} - {4'h0, b[7:4]} - bl;
        pn = hi[3];
        bh = hi[7];
        if (bh) hi = hi + DecAdjW;
        r.carry_out = ~bh;
        if (variant == VariantNmos) begin
          r.accumulator_out = {hi[3:0], lo[3:0]};
          r.negative_flag   = nb;
          r.overflow_flag   = vb;
          r.zero_flag       = (bin == 8'h00);
        end else begin
          // CMOS takes one more from the high digit if the low one stays negative
          hi  = hi - still_neg;
          acc = {hi[3:0], lo[3:0]};
          r.accumulator_out = acc;
          r.negative_flag   = acc[7];
          r.overflow_flag   = (a[7] ^ pn) & (~b[7] ^ pn);
          r.zero_flag       = (acc == 8'h00);
        end
      end
    end
    return r;
  endfunction

  function automatic step_row_t mk_step(logic op, logic dec, logic cin, logic [7:0] a,
                                        logic [7:0] b, bit known, logic [7:0] acc,
                                        logic n, logic v, logic z, logic c);
    step_row_t s;
    s.word      = '{op, dec, cin, a, b};
    s.known_ok  = known;
    s.known_res = '{acc, n, v, z, c};
    return s;
  endfunction

  // Mostly short gaps, some medium, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte(bit bcd_digits);
    logic [7:0] corner [5];
    corner = '{8'h00, 8'hFF, 8'h99, 8'h80, 8'h7F};
    if ($urandom_range(0, 19) == 0) return corner[$urandom_range(0, 4)];
    if (bcd_digits) return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    return 8'($urandom);
  endfunction

  // Decimal words are mostly valid BCD; the rest of the byte space is noise
  function automatic in_word_t random_word();
    in_word_t w;
    bit       bcd;
    w.operation    = 1'($urandom);
    w.decimal_mode = ($urandom_range(0, 9) < 6);
    w.carry_in     = 1'($urandom);
    bcd            = w.decimal_mode && ($urandom_range(0, 9) < 7);
    w.accumulator_in = pick_byte(bcd);
    w.operand_value  = pick_byte(bcd);
    return w;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    error_count++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, results_seen, field, got, want);
  endtask

  // Drive one word after a gap; hold it until accepted, then log its result
  task automatic send_word(in_word_t w, int gap, bit known, out_word_t known_res);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(known ? known_res : predict_adc_sbc(w, variant_now));
    words_sent++;
    if (w.decimal_mode) decimal_sent++;
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic drain_inputs();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_variant(logic v);
    drain_inputs();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk) cfg_wr_en <= 1'b0;
    variant_now = v;
    cfg_writes++;
  endtask

  // Result checker: compare against the oldest pending word
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("[%0t] result word with nothing pending: 0x%0h", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.accumulator_out !== want.accumulator_out)
          report_mismatch("accumulator", out_data.accumulator_out, want.accumulator_out);
        if (out_data.negative_flag !== want.negative_flag)
          report_mismatch("N", out_data.negative_flag, want.negative_flag);
        if (out_data.overflow_flag !== want.overflow_flag)
          report_mismatch("V", out_data.overflow_flag, want.overflow_flag);
        if (out_data.zero_flag !== want.zero_flag)
          report_mismatch("Z", out_data.zero_flag, want.zero_flag);
        if (out_data.carry_out !== want.carry_out)
          report_mismatch("C", out_data.carry_out, want.carry_out);
      end
      results_seen++;
    end
  end

  // Receiver: stretches of full speed mixed with short, medium and long stalls
  initial begin
    int   r;
    int   run;
    logic lvl;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        lvl = 1'b1;
        run = $urandom_range(5, 40);
      end else if (r < 85) begin
        lvl = 1'($urandom);
        run = $urandom_range(1, 3);
      end else if (r < 97) begin
        lvl = 1'b0;
        run = $urandom_range(4, 10);
      end else begin
        lvl = 1'b0;
        run = $urandom_range(20, 60);
      end
      repeat (run) @(negedge clk) out_ready <= lvl;
    end
  end

  initial begin
    out_word_t none;
    bit        burst;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    none         = '0;
    variant_now  = VariantNmos;
    error_count  = 0;
    words_sent   = 0;
    decimal_sent = 0;
    results_seen = 0;
    cfg_writes   = 0;

    // Binary rows carry hand-worked results; decimal rows go to the predictor
    corner_steps[0]  = mk_step(OpAdc, 0, 0, 8'h00, 8'h00, 1, 8'h00, 0, 0, 1, 0);
    corner_steps[1]  = mk_step(OpAdc, 0, 0, 8'hFF, 8'h01, 1, 8'h00, 0, 0, 1, 1);
    corner_steps[2]  = mk_step(OpAdc, 0, 0, 8'h7F, 8'h01, 1, 8'h80, 1, 1, 0, 0);
    corner_steps[3]  = mk_step(OpAdc, 0, 1, 8'hFF, 8'hFF, 1, 8'hFF, 1, 0, 0, 1);
    corner_steps[4]  = mk_step(OpSbc, 0, 1, 8'h00, 8'h01, 1, 8'hFF, 1, 0, 0, 0);
    corner_steps[5]  = mk_step(OpSbc, 0, 1, 8'h80, 8'h01, 1, 8'h7F, 0, 1, 0, 1);
    corner_steps[6]  = mk_step(OpSbc, 0, 0, 8'h00, 8'h00, 1, 8'hFF, 1, 0, 0, 0);
    // Decimal: wrap at 99, N quirk in the high digit, invalid digits both ways
    corner_steps[7]  = mk_step(OpAdc, 1, 0, 8'h99, 8'h01, 0, 0, 0, 0, 0, 0);
    corner_steps[8]  = mk_step(OpAdc, 1, 0, 8'h49, 8'h50, 0, 0, 0, 0, 0, 0);
    corner_steps[9]  = mk_step(OpAdc, 1, 1, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0);
    corner_steps[10] = mk_step(OpAdc, 1, 1, 8'h0F, 8'h0F, 0, 0, 0, 0, 0, 0);
    corner_steps[11] = mk_step(OpSbc, 1, 1, 8'h00, 8'h01, 0, 0, 0, 0, 0, 0);
    corner_steps[12] = mk_step(OpSbc, 1, 0, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0);
    // Low digit still negative after its +10 correction
    corner_steps[13] = mk_step(OpSbc, 1, 0, 8'h10, 8'h0F, 0, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed table: once at the reset variant, once after switching to CMOS
    foreach (corner_steps[i])
      send_word(corner_steps[i].word, 0, corner_steps[i].known_ok,
                corner_steps[i].known_res);
    set_variant(VariantCmos);
    foreach (corner_steps[i])
      send_word(corner_steps[i].word, idle_gap(), corner_steps[i].known_ok,
                corner_steps[i].known_res);

    // Random phases, alternating variants; some 50-word blocks run gap-free
    for (int p = 0; p < PhaseCount; p++) begin
      set_variant((p % 2 == 0) ? VariantNmos : VariantCmos);
      burst = 1'b0;
      for (int i = 0; i < PhaseWords; i++) begin
        if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
        // Hold the sender mid-phase until the pipeline is empty
        if (p == 3 && i == PhaseWords / 2) drain_inputs();
        send_word(random_word(), burst ? 0 : idle_gap(), 1'b0, none);
      end
    end

    drain_inputs();
    repeat (10) @(posedge clk);

    $display("Covered %0d words (%0d decimal), %0d results checked, %0d variant writes",
             words_sent, decimal_sent, results_seen, cfg_writes);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/bbas_pkg.sv
design/bbas_alu.sv
design/bcd_binary_add_subtract_flags.sv
tb/bcd_binary_add_subtract_flags_tb.sv
